FILE: design/aci_pkg.sv
package aci_pkg;

    // Addressing modes as shown on address_mode
    localparam logic [1:0] MODE_CHS   = 2'd0;
    localparam logic [1:0] MODE_LBA28 = 2'd1;
    localparam logic [1:0] MODE_LBA48 = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_PRI_CMD = 2'd0;
    localparam logic [1:0] REG_PRI_CTL = 2'd1;
    localparam logic [1:0] REG_SEC_CMD = 2'd2;
    localparam logic [1:0] REG_SEC_CTL = 2'd3;

    // Reset values of the I/O bases
    localparam logic [15:0] PRI_CMD_RESET = 16'h01F0;
    localparam logic [15:0] PRI_CTL_RESET = 16'h03F6;
    localparam logic [15:0] SEC_CMD_RESET = 16'h0170;
    localparam logic [15:0] SEC_CTL_RESET = 16'h0376;

    // Offsets inside the command and control blocks
    localparam logic [15:0] OFS_CTL    = 16'd2;
    localparam logic [15:0] OFS_COUNT  = 16'd2;
    localparam logic [15:0] OFS_LBA0   = 16'd3;
    localparam logic [15:0] OFS_LBA1   = 16'd4;
    localparam logic [15:0] OFS_LBA2   = 16'd5;
    localparam logic [15:0] OFS_DEVSEL = 16'd6;
    localparam logic [15:0] OFS_CMD    = 16'd7;

    // Register data bytes
    localparam logic [7:0] CTL_NIEN     = 8'h02;
    localparam logic [7:0] CTL_HOB      = 8'h82;
    localparam logic [7:0] DEV_CHS      = 8'hA0;
    localparam logic [7:0] DEV_LBA      = 8'hE0;
    localparam logic [7:0] CMD_READ     = 8'h20;
    localparam logic [7:0] CMD_READ_EXT = 8'h24;
    localparam logic [7:0] CMD_WRITE    = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    // CHS geometry: quotient by 63 through a reciprocal, 2^34 / 63 rounded down
    localparam int          SECTORS_PER_TRACK = 63;
    localparam int          RECIP_SHIFT       = 34;
    localparam logic [28:0] RECIP_63          = 29'd272696336;
    localparam int          PROD_W            = 57;
    localparam int          QUOT_W            = 23;

    // I/O bases as held in the configuration registers
    typedef struct packed {
        logic [15:0] pri_cmd;
        logic [15:0] pri_ctl;
        logic [15:0] sec_cmd;
        logic [15:0] sec_ctl;
    } base_cfg_t;

    // One classified request, ready for the write sequencer
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] ctl_port;
        logic [15:0] cmd_base;
        logic [7:0]  devsel;
        logic [7:0]  count;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  cmd;
    } desc_t;

    // Write sequencer steps, one per port write
    typedef enum logic [18:0] {
        ST_CTL      = 19'h00001,
        ST_DEVSEL   = 19'h00002,
        ST_H0_SET   = 19'h00004,
        ST_H0_REG   = 19'h00008,
        ST_H0_CLR   = 19'h00010,
        ST_H1_SET   = 19'h00020,
        ST_H1_REG   = 19'h00040,
        ST_H1_CLR   = 19'h00080,
        ST_H2_SET   = 19'h00100,
        ST_H2_REG   = 19'h00200,
        ST_H2_CLR   = 19'h00400,
        ST_H3_SET   = 19'h00800,
        ST_H3_REG   = 19'h01000,
        ST_H3_CLR   = 19'h02000,
        ST_COUNT    = 19'h04000,
        ST_LBA0     = 19'h08000,
        ST_LBA1     = 19'h10000,
        ST_LBA2     = 19'h20000,
        ST_CMD      = 19'h40000
    } step_t;

endpackage

FILE: design/aci_front.sv
module aci_front
    import aci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic        channel_select,
    input  logic        slave_select,
    input  logic        lba_capable,
    input  logic [31:0] block_address,
    input  logic [7:0]  sector_count,
    input  base_cfg_t   base_cfg,
    output logic        push,
    output desc_t       push_desc,
    input  logic        q_full
);

    logic                  s1_valid_reg;
    logic                  s1_func_reg;
    logic                  s1_chan_reg;
    logic                  s1_slave_reg;
    logic                  s1_lbacap_reg;
    logic [31:0]           s1_lba_reg;
    logic [7:0]            s1_count_reg;
    logic [PROD_W-1:0]     s1_prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic                  s1_load;

    logic [QUOT_W-1:0]     q0;
    logic [28:0]           q0_x63;
    logic [28:0]           rem_wide;
    logic [6:0]            rem_raw;
    logic [QUOT_W-1:0]     quot;
    logic [5:0]            rem;
    logic [15:0]           cyl;
    logic [3:0]            head;
    logic                  is48;
    logic [15:0]           cmd_base;
    logic [15:0]           ctl_base;

    // Hand over to the queue; take a new request when stage one frees
    assign push     = s1_valid_reg && !q_full;
    assign s1_load  = !s1_valid_reg || push;
    assign in_stall = s1_valid_reg && q_full;

    // Reciprocal product for the division by sectors per track
    assign prod_next = {29'b0, block_address[27:0]} * {28'b0, RECIP_63};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Hold the request and its product in stage one
    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_func_reg   <= func;
            s1_chan_reg   <= channel_select;
            s1_slave_reg  <= slave_select;
            s1_lbacap_reg <= lba_capable;
            s1_lba_reg    <= block_address;
            s1_count_reg  <= sector_count;
            s1_prod_reg   <= prod_next;
        end
    end

    // Correct the estimated quotient by at most one
    always_comb
    begin
        q0       = s1_prod_reg[RECIP_SHIFT +: QUOT_W];
        q0_x63   = {q0, 6'b0} - {6'b0, q0};
        rem_wide = {1'b0, s1_lba_reg[27:0]} - q0_x63;
        rem_raw  = rem_wide[6:0];
        if (rem_raw >= 7'(SECTORS_PER_TRACK))
        begin
            quot = q0 + QUOT_W'(1);
            rem  = 6'(rem_raw - 7'(SECTORS_PER_TRACK));
        end
        else
        begin
            quot = q0;
            rem  = rem_raw[5:0];
        end
        cyl  = quot[19:4];
        head = quot[3:0];
    end

    // Classify and build the descriptor
    always_comb
    begin
        is48     = |s1_lba_reg[31:28];
        cmd_base = s1_chan_reg ? base_cfg.sec_cmd : base_cfg.pri_cmd;
        ctl_base = s1_chan_reg ? base_cfg.sec_ctl : base_cfg.pri_ctl;

        push_desc          = '0;
        push_desc.ctl_port = ctl_base + OFS_CTL;
        push_desc.cmd_base = cmd_base;
        push_desc.count    = s1_count_reg;

        if (is48)
        begin
            push_desc.mode   = MODE_LBA48;
            push_desc.b0     = s1_lba_reg[7:0];
            push_desc.b1     = s1_lba_reg[15:8];
            push_desc.b2     = s1_lba_reg[23:16];
            push_desc.b3     = s1_lba_reg[31:24];
            push_desc.devsel = DEV_LBA | {3'b0, s1_slave_reg, 4'b0};
        end
        else if (s1_lbacap_reg)
        begin
            push_desc.mode   = MODE_LBA28;
            push_desc.b0     = s1_lba_reg[7:0];
            push_desc.b1     = s1_lba_reg[15:8];
            push_desc.b2     = s1_lba_reg[23:16];
            push_desc.b3     = 8'h00;
            push_desc.devsel = DEV_LBA | {3'b0, s1_slave_reg, s1_lba_reg[27:24]};
        end
        else
        begin
            push_desc.mode   = MODE_CHS;
            push_desc.b0     = {2'b0, rem} + 8'd1;
            push_desc.b1     = cyl[7:0];
            push_desc.b2     = cyl[15:8];
            push_desc.b3     = 8'h00;
            push_desc.devsel = DEV_CHS | {3'b0, s1_slave_reg, head};
        end

        if (s1_func_reg)
        begin
            push_desc.cmd = is48 ? CMD_WRITE_EXT : CMD_WRITE;
        end
        else
        begin
            push_desc.cmd = is48 ? CMD_READ_EXT : CMD_READ;
        end
    end

endmodule

FILE: design/aci_queue.sv
module aci_queue
    import aci_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc
);

    desc_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full       = fill_reg == 2'd2;
    assign head_valid = fill_reg != 2'd0;
    assign head_desc  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // Advance the pointers and the fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Store the incoming descriptor
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

FILE: design/aci_back.sv
module aci_back
    import aci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  desc_t       head_desc,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] port_address,
    output logic [7:0]  port_data,
    output logic [1:0]  address_mode,
    output logic        last_write
);

    step_t       step_reg;
    step_t       step_next;
    logic        emit;
    logic        out_valid_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [1:0]  mode_reg;
    logic        last_reg;
    logic [15:0] cur_addr;
    logic [7:0]  cur_data;
    logic        cur_last;

    assign emit = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = emit && (step_reg == ST_CMD);

    // Port write for the current step
    always_comb
    begin
        cur_addr  = head_desc.ctl_port;
        cur_data  = CTL_NIEN;
        cur_last  = 1'b0;
        step_next = ST_CTL;
        case (step_reg)
            ST_CTL:
            begin
                step_next = ST_DEVSEL;
            end
            ST_DEVSEL:
            begin
                cur_addr  = head_desc.cmd_base + OFS_DEVSEL;
                cur_data  = head_desc.devsel;
                step_next = (head_desc.mode == MODE_LBA48) ? ST_H0_SET : ST_COUNT;
            end
            ST_H0_SET:
            begin
                cur_data  = CTL_HOB;
                step_next = ST_H0_REG;
            end
            ST_H0_REG:
            begin
                cur_addr  = head_desc.cmd_base + OFS_COUNT;
                cur_data  = 8'h00;
                step_next = ST_H0_CLR;
            end
            ST_H0_CLR:
            begin
                step_next = ST_H1_SET;
            end
            ST_H1_SET:
            begin
                cur_data  = CTL_HOB;
                step_next = ST_H1_REG;
            end
            ST_H1_REG:
            begin
                cur_addr  = head_desc.cmd_base + OFS_LBA0;
                cur_data  = head_desc.b3;
                step_next = ST_H1_CLR;
            end
            ST_H1_CLR:
            begin
                step_next = ST_H2_SET;
            end
            ST_H2_SET:
            begin
                cur_data  = CTL_HOB;
                step_next = ST_H2_REG;
            end
            ST_H2_REG:
            begin
                cur_addr  = head_desc.cmd_base + OFS_LBA1;
                cur_data  = 8'h00;
                step_next = ST_H2_CLR;
            end
            ST_H2_CLR:
            begin
                step_next = ST_H3_SET;
            end
            ST_H3_SET:
            begin
                cur_data  = CTL_HOB;
                step_next = ST_H3_REG;
            end
            ST_H3_REG:
            begin
                cur_addr  = head_desc.cmd_base + OFS_LBA2;
                cur_data  = 8'h00;
                step_next = ST_H3_CLR;
            end
            ST_H3_CLR:
            begin
                step_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                cur_addr  = head_desc.cmd_base + OFS_COUNT;
                cur_data  = head_desc.count;
                step_next = ST_LBA0;
            end
            ST_LBA0:
            begin
                cur_addr  = head_desc.cmd_base + OFS_LBA0;
                cur_data  = head_desc.b0;
                step_next = ST_LBA1;
            end
            ST_LBA1:
            begin
                cur_addr  = head_desc.cmd_base + OFS_LBA1;
                cur_data  = head_desc.b1;
                step_next = ST_LBA2;
            end
            ST_LBA2:
            begin
                cur_addr  = head_desc.cmd_base + OFS_LBA2;
                cur_data  = head_desc.b2;
                step_next = ST_CMD;
            end
            ST_CMD:
            begin
                cur_addr  = head_desc.cmd_base + OFS_CMD;
                cur_data  = head_desc.cmd;
                cur_last  = 1'b1;
                step_next = ST_CTL;
            end
            default:
            begin
                step_next = ST_CTL;
            end
        endcase
    end

    // Advance the sequencer and the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_CTL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                step_reg <= step_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            addr_reg <= cur_addr;
            data_reg <= cur_data;
            mode_reg <= head_desc.mode;
            last_reg <= cur_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign port_address = addr_reg;
    assign port_data    = data_reg;
    assign address_mode = mode_reg;
    assign last_write   = last_reg;

endmodule

FILE: design/ata_pio_command_issue_unit.sv
// Channel   Direction  Handshake                  Payload
// in        sink       in_valid / in_stall        func, channel_select, slave_select,
//                                                 lba_capable, block_address, sector_count
// out       source     out_valid / out_stall      port_address, port_data,
//                                                 address_mode, last_write
// cfg       sink       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A request makes 7 port writes on the result channel for CHS and LBA28 and 19 for
// LBA48: the write sequencer emits one port write per cycle while out_stall is low
// and sets the rate. The first result is registered in the classify stage, then in
// the queue, then in the output register. Reset clears the pipeline and queue and
// loads the default I/O bases. A stall on the result side holds the output
// register; up to three further requests are taken before in_stall rises.
module ata_pio_command_issue_unit
    import aci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic        channel_select,
    input  logic        slave_select,
    input  logic        lba_capable,
    input  logic [31:0] block_address,
    input  logic [7:0]  sector_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] port_address,
    output logic [7:0]  port_data,
    output logic [1:0]  address_mode,
    output logic        last_write,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    base_cfg_t base_cfg_reg;
    logic      push;
    desc_t     push_desc;
    logic      q_full;
    logic      pop;
    logic      head_valid;
    desc_t     head_desc;

    assign cfg_ready = 1'b1;

    // Write the I/O base registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg.pri_cmd <= PRI_CMD_RESET;
            base_cfg_reg.pri_ctl <= PRI_CTL_RESET;
            base_cfg_reg.sec_cmd <= SEC_CMD_RESET;
            base_cfg_reg.sec_ctl <= SEC_CTL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PRI_CMD: base_cfg_reg.pri_cmd <= cfg_data;
                REG_PRI_CTL: base_cfg_reg.pri_ctl <= cfg_data;
                REG_SEC_CMD: base_cfg_reg.sec_cmd <= cfg_data;
                REG_SEC_CTL: base_cfg_reg.sec_ctl <= cfg_data;
                default:     base_cfg_reg         <= base_cfg_reg;
            endcase
        end
    end

    aci_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .channel_select (channel_select),
        .slave_select   (slave_select),
        .lba_capable    (lba_capable),
        .block_address  (block_address),
        .sector_count   (sector_count),
        .base_cfg       (base_cfg_reg),
        .push           (push),
        .push_desc      (push_desc),
        .q_full         (q_full)
    );

    aci_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    aci_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_desc    (head_desc),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .port_address (port_address),
        .port_data    (port_data),
        .address_mode (address_mode),
        .last_write   (last_write)
    );

endmodule

FILE: design/aci_checker.sv
module aci_checker
    import aci_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] port_address,
    input logic [7:0]  port_data,
    input logic [1:0]  address_mode,
    input logic        last_write
);

    // A sequence in progress runs on without a gap and keeps its mode
    a_seq_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_write
        |=> out_valid && address_mode == $past(address_mode))
        else $error("port write sequence broken or mode changed");

    // A stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall
        |=> out_valid && $stable(port_address) && $stable(port_data)
            && $stable(last_write))
        else $error("stalled result changed");

    // The closing write carries a PIO command matching the mode
    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_write
        |-> (address_mode == MODE_LBA48 && (port_data == CMD_READ_EXT
                                            || port_data == CMD_WRITE_EXT))
            || (address_mode != MODE_LBA48 && (port_data == CMD_READ
                                               || port_data == CMD_WRITE)))
        else $error("command byte does not match address mode");

    // A sequence that follows straight on a closing write opens with the interrupt-disable control write
    a_first_ctl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_write
        |=> !out_valid || port_data == CTL_NIEN)
        else $error("sequence does not open with control write");

endmodule

bind ata_pio_command_issue_unit aci_checker u_aci_checker (.*);
